/* rtl/skta_pkg.sv */
// Shared types and constants for the three-axis scalar Kalman filter.
`default_nettype none
package skta_pkg;

    localparam int AXIS_BITS   = 2;
    localparam int SAMPLE_BITS = 16;
    localparam int Q_BITS      = 16;
    localparam int R_BITS      = 18;
    localparam int COV_BITS    = 20;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 18;

    localparam logic [Q_BITS-1:0]   Q_RESET = 16'd197;
    localparam logic [R_BITS-1:0]   R_RESET = 18'd6554;
    localparam logic [COV_BITS-1:0] COV_MAX = {COV_BITS{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE     = 1'b0,
        REG_MEASUREMENT_NOISE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_init;
        logic div_step;
        logic mul;
        logic acc;
        logic rnd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/scalar_kalman_three_axis.sv */
// Top level of the three-axis scalar Kalman filter.
//
//  channel   direction  tdata               tuser
//  s_axis    in         [15:0] sample       [1:0] axis
//  m_axis    out        [15:0] filtered     [1:0] axis_out
//  cfg       in         write: i_cfg_we, i_cfg_idx, i_cfg_data
//
// One sample at a time; the pace from transfer to transfer is set by the
// one-bit-per-cycle gain divider.
// The output register holds one result; a new sample is taken while it waits.
// A stalled output holds the engine in its last step until the result is taken.
// Synchronous active-low reset restores Q, R, covariance = 1.0 and zero history.
`default_nettype none
module scalar_kalman_three_axis
    import skta_pkg::*;
#(
    parameter int AXES      = 3,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [SAMPLE_BITS-1:0] s_axis_tdata,  // [15:0] sample
    input  wire logic [AXIS_BITS-1:0]   s_axis_tuser,  // [1:0] axis
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [SAMPLE_BITS-1:0]      m_axis_tdata,  // [15:0] filtered
    output logic [AXIS_BITS-1:0]        m_axis_tuser,  // [1:0] axis_out
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    skta_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    skta_dp #(
        .AXES      (AXES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_axis      (s_axis_tuser),
        .i_sample    (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_axis      (m_axis_tuser),
        .o_filtered  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while previous sample in flight");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result committed over an untaken result");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> m_axis_tvalid)
        else $error("committed result not presented");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("overlapping datapath commands");
`endif

endmodule
`default_nettype wire

/* rtl/skta_ctrl.sv */
// Sequencer for one sample: gain division steps, multiplies, rounding, commit.
`default_nettype none
module skta_ctrl
    import skta_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DINIT,
        S_DIV,
        S_MUL,
        S_ACC,
        S_RND,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_PREP;
                end
                S_PREP:  r_state <= S_DINIT;
                S_DINIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(FRAC_BITS - 1)) r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: r_state <= S_RND;
                S_RND: r_state <= S_OUT;
                S_OUT: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.div_init = (r_state == S_DINIT);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.acc      = (r_state == S_ACC);
        o_cmd.rnd      = (r_state == S_RND);
        o_cmd.commit   = (r_state == S_OUT) && i_stat.out_free;
    end

endmodule
`default_nettype wire

/* rtl/skta_dp.sv */
// Datapath: noise registers, covariance, per-axis history, divider, multipliers, output register.
`default_nettype none
module skta_dp
    import skta_pkg::*;
#(
    parameter int AXES      = 3,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat,
    input  wire logic [AXIS_BITS-1:0]   i_axis,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [AXIS_BITS-1:0]        o_axis,
    output logic [SAMPLE_BITS-1:0]      o_filtered
);

    localparam int K_W      = FRAC_BITS + 1;
    localparam int DEN_W    = COV_BITS + 1;
    localparam int PROD_W   = K_W + 1 + SAMPLE_BITS + 1;
    localparam int V_W      = PROD_W + 1;
    localparam int CPROD_W  = COV_BITS + K_W;
    localparam int AX_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic [K_W-1:0] ONE_K = K_W'(1) << FRAC_BITS;
    localparam logic [V_W-1:0] ONE_M1 = (V_W'(1) << FRAC_BITS) - V_W'(1);
    localparam logic [COV_BITS-1:0] COV_RST =
        (FRAC_BITS >= COV_BITS) ? COV_MAX : COV_BITS'(64'd1 << FRAC_BITS);

    logic [Q_BITS-1:0]            r_q;
    logic [R_BITS-1:0]            r_r;
    logic [COV_BITS-1:0]          r_cov;
    logic signed [SAMPLE_BITS-1:0] r_prev [AXES];

    logic [AXIS_BITS-1:0]          r_axis;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_ok;
    logic signed [SAMPLE_BITS-1:0] r_prev_sel;
    logic [COV_BITS-1:0]           r_p1;
    logic [DEN_W-1:0]              r_den;
    logic [DEN_W-1:0]              r_rem;
    logic [K_W-1:0]                r_k;
    logic                          r_keq;
    logic signed [PROD_W-1:0]      r_prod;
    logic [CPROD_W-1:0]            r_cprod;
    logic signed [V_W-1:0]         r_v;
    logic [SAMPLE_BITS-1:0]        r_res;

    logic                          r_out_valid;
    logic [AXIS_BITS-1:0]          r_out_axis;
    logic [SAMPLE_BITS-1:0]        r_out_data;

    logic [AX_IDX_W-1:0]           w_idx;
    logic                          w_ok;
    logic [COV_BITS:0]             w_psum;
    logic [DEN_W:0]                w_rem2;
    logic                          w_qbit;
    logic [K_W-1:0]                w_k_eff;
    logic signed [K_W:0]           w_k_s;
    logic signed [SAMPLE_BITS:0]   w_diff;
    logic [K_W-1:0]                w_onemk;
    logic signed [V_W-1:0]         w_vb;
    logic signed [V_W-1:0]         w_sh;

    assign w_idx   = AX_IDX_W'(r_axis);
    assign w_ok    = (32'(r_axis) < AXES);
    assign w_psum  = {1'b0, r_cov} + (COV_BITS + 1)'(r_q);
    assign w_rem2  = {r_rem, 1'b0};
    assign w_qbit  = (w_rem2 >= {1'b0, r_den});
    assign w_k_eff = r_keq ? ONE_K : r_k;
    assign w_k_s   = {1'b0, w_k_eff};
    assign w_diff  = {r_x[SAMPLE_BITS-1], r_x} - {r_prev_sel[SAMPLE_BITS-1], r_prev_sel};
    assign w_onemk = ONE_K - w_k_eff;
    assign w_vb    = r_v + (r_v[V_W-1] ? ONE_M1 : '0);
    assign w_sh    = w_vb >>> FRAC_BITS;

    // configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= Q_RESET;
            r_r   <= R_RESET;
            r_cov <= COV_RST;
            for (int i = 0; i < AXES; i++) r_prev[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PROCESS_NOISE:     r_q <= i_cfg_data[Q_BITS-1:0];
                    REG_MEASUREMENT_NOISE: r_r <= i_cfg_data[R_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit && r_ok) begin
                r_cov         <= r_cprod[FRAC_BITS +: COV_BITS];
                r_prev[w_idx] <= r_res;
            end
        end
    end

    // per-sample working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_axis <= i_axis;
            r_x    <= i_sample;
        end
        if (i_cmd.prep) begin
            r_ok       <= w_ok;
            r_prev_sel <= w_ok ? r_prev[w_idx] : '0;
            r_p1       <= w_psum[COV_BITS] ? COV_MAX : w_psum[COV_BITS-1:0];
        end
        if (i_cmd.div_init) begin
            r_den <= {1'b0, r_p1} + DEN_W'(r_r);
            r_rem <= {1'b0, r_p1};
            r_k   <= '0;
            r_keq <= (r_r == '0);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_qbit ? DEN_W'(w_rem2 - {1'b0, r_den}) : w_rem2[DEN_W-1:0];
            r_k   <= {r_k[K_W-2:0], w_qbit};
        end
        if (i_cmd.mul) begin
            r_prod  <= w_k_s * w_diff;
            r_cprod <= r_p1 * w_onemk;
        end
        if (i_cmd.acc) begin
            r_v <= (V_W'(r_prev_sel) <<< FRAC_BITS) + V_W'(r_prod);
        end
        if (i_cmd.rnd) begin
            r_res <= w_sh[SAMPLE_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_axis <= r_axis;
            r_out_data <= r_ok ? r_res : '0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_axis          = r_out_axis;
    assign o_filtered      = r_out_data;

endmodule
`default_nettype wire
